// ----- rtl/bakery_ticket_arbiter_top_assert.svh -----
// Assertion shorthands for the arbiter's port checker.
// Both sample on clk and are off while rst_n is low.
`ifndef BAKERY_TICKET_ARBITER_TOP_ASSERT_SVH
`define BAKERY_TICKET_ARBITER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BTA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bta_pkg.sv -----
package bta_pkg;

  localparam int PROCS_DEF       = 16;
  localparam int TICKET_BITS_DEF = 16;

  // fixed field widths on the ports
  localparam int PID_W = 4;
  localparam int GID_W = 4;
  localparam int TKO_W = 16;
  localparam int IN_W  = 8;
  localparam int OUT_W = 24;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_AGAIN    = 2'd1,
    ST_NOTICKET = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ENTER = 1'b0,
    REQ_LEAVE = 1'b1
  } req_t;

  // grant_valid lands in bit 0
  typedef struct packed {
    status_t           status;
    logic [TKO_W-1:0]  ticket;
    logic [GID_W-1:0]  grant_id;
    logic              grant_valid;
  } result_t;

  typedef struct packed {
    logic start;
    logic take;
  } core_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_sts_t;

endpackage

// ----- rtl/bakery_ticket_arbiter_top.sv -----
// Bakery ticket arbiter. Each input beat is an enter or leave request from
// one requester; each yields one result beat with the current lock holder
// (smallest live ticket, ties to the lower id), the ticket handed out on a
// good enter, and a status code. Tickets sit in a memory with one read
// port and registered reads; every beat makes one full pass over it to find
// the largest ticket and the holder, then writes the issuer's entry back on
// a good enter or leave. One beat is in work at a time: a new beat is taken
// only once the finished result has moved into an output register (held
// back while that register is full and stalled); the result waits there,
// so the next beat may enter meanwhile. Per-entry valid bits make the
// memory read as all zero right after reset; there is no clearing pass.
module bakery_ticket_arbiter_top import bta_pkg::*; #(
  parameter int PROCS       = PROCS_DEF,
  parameter int TICKET_BITS = TICKET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // [3:0] proc_id, [7:4] zero
  input  logic             in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [0] grant_valid, [4:1] grant_id,
                                       // [20:5] ticket_out, [22:21] status,
                                       // [23] zero
);

  core_ctl_t        ctl;
  core_sts_t        sts;
  result_t          core_res;
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_data_r;

  assign in_tready = sts.idle;
  assign ctl.start = in_tvalid && sts.idle;
  assign ctl.take  = sts.done && (!out_tvalid_r || out_tready);

  bta_core #(
    .PROCS       (PROCS),
    .TICKET_BITS (TICKET_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .req_type (in_tuser),
    .proc_id  (in_tdata[PID_W-1:0]),
    .sts      (sts),
    .result   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      out_data_r <= {1'b0, core_res};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/bta_core.sv -----
module bta_core import bta_pkg::*; #(
  parameter int PROCS       = PROCS_DEF,
  parameter int TICKET_BITS = TICKET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  core_ctl_t        ctl,
  input  logic             req_type,
  input  logic [PID_W-1:0] proc_id,
  output core_sts_t        sts,
  output result_t          result
);

  localparam int IDX_W = $clog2(PROCS);
  localparam int CNT_W = $clog2(PROCS + 1);
  localparam int EXT_W = PID_W + IDX_W;
  localparam logic [TICKET_BITS-1:0] TK_ALL1 = '1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_DONE} state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   leave_r;
  logic [IDX_W-1:0]       pid_r;
  logic                   pok_r;
  logic [TICKET_BITS-1:0] max_r;
  logic [TICKET_BITS-1:0] own_r;
  logic [TICKET_BITS-1:0] best_r;
  logic [IDX_W-1:0]       best_id_r;
  logic                   found_r;
  result_t                result_r;

  logic [TICKET_BITS-1:0] tk_mem [PROCS];
  logic [PROCS-1:0]       live_r;
  logic [TICKET_BITS-1:0] rd_data_r;

  logic [EXT_W-1:0]       pid_ext;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [CNT_W-1:0]       prev_cnt;
  logic [IDX_W-1:0]       prev_idx;
  logic                   is_own;

  logic                   mem_we;
  logic [TICKET_BITS-1:0] new_p;
  logic [TICKET_BITS-1:0] tk_give;
  status_t                st;
  logic                   p_wins;
  logic                   win_valid;
  logic [IDX_W-1:0]       win_id;
  logic [EXT_W-1:0]       gid_ext;
  logic [TKO_W+TICKET_BITS-1:0] tk_ext;

  assign pid_ext  = {{IDX_W{1'b0}}, proc_id};
  assign rd_en    = (state_r == S_SCAN) && (cnt_r < CNT_W'(PROCS));
  assign rd_addr  = cnt_r[IDX_W-1:0];
  assign prev_cnt = cnt_r - CNT_W'(1);
  assign prev_idx = prev_cnt[IDX_W-1:0];
  assign is_own   = pok_r && (prev_idx == pid_r);

  // ticket memory, one read port; entries never written read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= live_r[rd_addr] ? tk_mem[rd_addr] : '0;
    end
    if (mem_we) begin
      tk_mem[pid_r] <= new_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (mem_we) begin
      live_r[pid_r] <= 1'b1;
    end
  end

  // outcome of the item, from the scan totals
  always_comb begin
    mem_we  = 1'b0;
    new_p   = own_r;
    tk_give = '0;
    st      = ST_OK;
    if (pok_r) begin
      if (leave_r == REQ_ENTER) begin
        if (own_r != '0) begin
          st = ST_AGAIN;
        end else if (max_r == TK_ALL1) begin
          st = ST_OVERFLOW;
        end else begin
          tk_give = max_r + TICKET_BITS'(1);
          new_p   = tk_give;
          mem_we  = (state_r == S_DECIDE);
        end
      end else begin
        if (own_r == '0) begin
          st = ST_NOTICKET;
        end else begin
          new_p  = '0;
          mem_we = (state_r == S_DECIDE);
        end
      end
    end

    // the issuer's entry was left out of the scan minimum; merge it here
    p_wins = pok_r && (new_p != '0) &&
             (!found_r || (new_p < best_r) || ((new_p == best_r) && (pid_r < best_id_r)));
    win_valid = found_r || p_wins;
    win_id    = p_wins ? pid_r : (found_r ? best_id_r : '0);
    gid_ext   = {{PID_W{1'b0}}, win_id};
    tk_ext    = {{TKO_W{1'b0}}, tk_give};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (ctl.start) begin
            leave_r <= req_type;
            pid_r   <= pid_ext[IDX_W-1:0];
            pok_r   <= pid_ext < EXT_W'(PROCS);
            cnt_r   <= '0;
            max_r   <= '0;
            own_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r != '0) begin
            if (rd_data_r > max_r) begin
              max_r <= rd_data_r;
            end
            if (is_own) begin
              own_r <= rd_data_r;
            end else if ((rd_data_r != '0) && (!found_r || (rd_data_r < best_r))) begin
              found_r   <= 1'b1;
              best_r    <= rd_data_r;
              best_id_r <= prev_idx;
            end
          end
          if (cnt_r == CNT_W'(PROCS)) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          result_r.grant_valid <= win_valid;
          result_r.grant_id    <= gid_ext[GID_W-1:0];
          result_r.ticket      <= tk_ext[TKO_W-1:0];
          result_r.status      <= st;
          state_r              <= S_DONE;
        end
        S_DONE: begin
          if (ctl.take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign sts.idle = (state_r == S_IDLE);
  assign sts.done = (state_r == S_DONE);
  assign result   = result_r;

endmodule

// ----- rtl/bta_checker.sv -----
`include "bakery_ticket_arbiter_top_assert.svh"

module bta_checker import bta_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic in_beat;
  assign in_beat = in_tvalid && in_tready;

  // a stalled result beat must not change
  `BTA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // a handed-out ticket means a clean enter, and the lock is then held
  `BTA_ASSERT_SAME(a_ticket_ok, out_tvalid && (out_tdata[20:5] != '0), (out_tdata[22:21] == ST_OK) && out_tdata[0], "ticket given with bad status or no holder")

  // no holder reports id zero
  `BTA_ASSERT_SAME(a_idle_id, out_tvalid && !out_tdata[0], out_tdata[4:1] == '0, "holder id set without a holder")

  // a beat is never taken in the cycle right after another one
  `BTA_ASSERT_NEXT(a_in_gap, in_beat, !in_tready, "input taken on consecutive cycles")

endmodule

bind bakery_ticket_arbiter_top bta_checker u_bta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
